// ----- rtl/life_generation_torus_assert.svh -----
// Assertion macros for the life generation torus block.
// Included by the checker module; needs nothing else.
`ifndef LIFE_GENERATION_TORUS_ASSERT_SVH
`define LIFE_GENERATION_TORUS_ASSERT_SVH

// Same-cycle implication, reset masks the check
`define LGT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check
`define LGT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lgt_pkg.sv -----
// Shared sizes, request codes and register indexes for the life generation torus.
// No dependencies.
`timescale 1ns / 1ps

package lgt_pkg;

  // Grid limits: one memory word per column, one bit per row
  localparam int MaxCols = 64;
  localparam int MaxRows = 64;
  localparam int ColW    = $clog2(MaxCols);
  localparam int RowW    = $clog2(MaxRows);

  // Size registers and the step counter
  localparam int SizeW = 7;
  localparam int CntW  = 7;

  // Configuration port
  localparam int CfgIdxW = 2;

  // Rule counts
  localparam logic [3:0] BirthCount = 4'd3;
  localparam logic [3:0] KeepCount  = 4'd2;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_STEP = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1
  } cfg_idx_e;

endpackage

// ----- rtl/lgt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lgt_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/life_generation_torus.sv -----
// Life generation torus (B3/S23) on a wrapping grid of up to 64 x 64 cells, one
// memory word per column. A load or a read passes through accept, memory access
// and result; a step streams the columns through the memory: one column word read
// and one new column written back per cycle through a three-column window.
// After reset all cells read as dead through per-column valid bits, so no clearing
// pass is needed.
// Depends on lgt_pkg and lgt_ram.
`timescale 1ns / 1ps

module life_generation_torus (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lgt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lgt_pkg::SizeW-1:0]    cfg_data_i,
  // request items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic [lgt_pkg::ColW-1:0]     cell_col_i,
  input  logic [lgt_pkg::RowW-1:0]     cell_row_i,
  input  logic                         cell_in_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         cell_out_o,
  output logic                         status_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ACCESS = 4'b0010,
    ST_STEP   = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

  localparam int MaxCols = lgt_pkg::MaxCols;
  localparam int MaxRows = lgt_pkg::MaxRows;
  localparam int ColW    = lgt_pkg::ColW;
  localparam int RowW    = lgt_pkg::RowW;
  localparam int SizeW   = lgt_pkg::SizeW;
  localparam int CntW    = lgt_pkg::CntW;

  // Saturate a size register: zero counts as one, large values clip
  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] v,
                                                input logic [SizeW-1:0] lim);
    logic [SizeW-1:0] r;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  state_e               state_q, state_d;
  lgt_pkg::req_e        req_q, req_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [RowW-1:0]      row_q, row_d;
  logic                 val_q, val_d;
  logic [SizeW-1:0]     cols_q, rows_q;
  logic [CntW-1:0]      k_q, k_d;
  logic [MaxRows-1:0]   left_q, left_d, mid_q, mid_d, save_q, save_d;
  logic                 rd_vld_q;
  logic [MaxCols-1:0]   vld_q;
  logic                 res_cell_q, res_cell_d, res_stat_q, res_stat_d;
  logic                 out_valid_q, out_valid_d, cell_out_q, cell_out_d;
  logic                 status_q, status_d;

  logic                 in_acc, in_range;
  logic                 ram_we, ram_re;
  logic [ColW-1:0]      ram_waddr, ram_raddr;
  logic [MaxRows-1:0]   ram_wdata, ram_rdata;
  logic [MaxRows-1:0]   rd_word, in_word, next_word;
  logic [CntW-1:0]      k_last;

  // Column store: word c holds every row of column c
  lgt_ram #(
    .Width(MaxRows),
    .Depth(MaxCols)
  ) u_grid (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign in_range    = ({1'b0, cell_col_i} < cols_q) && ({1'b0, cell_row_i} < rows_q);

  // Column never written since reset reads as all dead
  assign rd_word = ram_rdata & {MaxRows{rd_vld_q}};
  // Last step cycle feeds the saved first column as right neighbour of the last
  assign k_last  = CntW'(cols_q) + CntW'(2);
  assign in_word = (k_q == k_last) ? save_q : rd_word;

  // New column from three neighbouring columns, vertical wrap at rows_q
  always_comb begin : p_life
    logic [RowW-1:0] last_row;
    logic [RowW-1:0] cur_r;
    logic [RowW-1:0] up_r;
    logic [RowW-1:0] dn_r;
    logic [3:0]      cnt;
    last_row  = RowW'(rows_q - SizeW'(1));
    next_word = mid_q;
    for (int i = 0; i < MaxRows; i++) begin
      cur_r = RowW'(i);
      up_r  = (cur_r == '0) ? last_row : RowW'(i - 1);
      dn_r  = (cur_r == last_row) ? '0 : RowW'(i + 1);
      cnt   = 4'(left_q[up_r]) + 4'(left_q[cur_r]) + 4'(left_q[dn_r]) +
              4'(mid_q[up_r]) + 4'(mid_q[dn_r]) +
              4'(in_word[up_r]) + 4'(in_word[cur_r]) + 4'(in_word[dn_r]);
      if (SizeW'(i) < rows_q) begin
        next_word[i] = (mid_q[i] && (cnt == lgt_pkg::KeepCount)) ||
                       (cnt == lgt_pkg::BirthCount);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    col_d      = col_q;
    row_d      = row_q;
    val_d      = val_q;
    k_d        = k_q;
    left_d     = left_q;
    mid_d      = mid_q;
    save_d     = save_q;
    res_cell_d = res_cell_q;
    res_stat_d = res_stat_q;
    ram_we     = 1'b0;
    ram_waddr  = col_q;
    ram_wdata  = rd_word;
    ram_re     = 1'b0;
    ram_raddr  = cell_col_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d      = lgt_pkg::req_e'(req_type_i);
          col_d      = cell_col_i;
          row_d      = cell_row_i;
          val_d      = cell_in_i;
          res_cell_d = 1'b0;
          res_stat_d = 1'b0;
          k_d        = '0;
          unique case (lgt_pkg::req_e'(req_type_i)) inside
            lgt_pkg::REQ_LOAD, lgt_pkg::REQ_READ: begin
              if (in_range) begin
                ram_re  = 1'b1;
                state_d = ST_ACCESS;
              end else begin
                res_stat_d = 1'b1;
                state_d    = ST_RESP;
              end
            end
            lgt_pkg::REQ_STEP: state_d = ST_STEP;
            default:           state_d = ST_RESP;
          endcase
        end
      end

      ST_ACCESS: begin
        // load: read-modify-write of one column word; read: take the addressed cell
        if (req_q == lgt_pkg::REQ_LOAD) begin
          ram_we            = 1'b1;
          ram_waddr         = col_q;
          ram_wdata         = rd_word;
          ram_wdata[row_q]  = val_q;
        end else begin
          res_cell_d = rd_word[row_q];
        end
        state_d = ST_RESP;
      end

      ST_STEP: begin
        // issue: last column first, then columns 0 .. cols-1
        if (k_q <= CntW'(cols_q)) begin
          ram_re    = 1'b1;
          ram_raddr = (k_q == '0) ? ColW'(cols_q - SizeW'(1)) : ColW'(k_q - CntW'(1));
        end
        // arrival: shift the window, keep old column 0 for the wrap
        if (k_q != '0) begin
          left_d = mid_q;
          mid_d  = in_word;
          if (k_q == CntW'(2)) begin
            save_d = in_word;
          end
        end
        // window complete: write back the middle column
        if (k_q >= CntW'(3)) begin
          ram_we    = 1'b1;
          ram_waddr = ColW'(k_q - CntW'(3));
          ram_wdata = next_word;
        end
        k_d = k_q + CntW'(1);
        if (k_q == k_last) begin
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    cell_out_d  = cell_out_q;
    status_d    = status_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == ST_RESP) && (!out_valid_q || !out_stall_i)) begin
      out_valid_d = 1'b1;
      cell_out_d  = res_cell_q;
      status_d    = res_stat_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      k_q         <= '0;
      cols_q      <= SizeW'(MaxCols);
      rows_q      <= SizeW'(MaxRows);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (cfg_valid_i) begin
        unique case (lgt_pkg::cfg_idx_e'(cfg_index_i))
          lgt_pkg::CFG_COLS: cols_q <= eff_size(cfg_data_i, SizeW'(MaxCols));
          lgt_pkg::CFG_ROWS: rows_q <= eff_size(cfg_data_i, SizeW'(MaxRows));
          default: ;
        endcase
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    col_q      <= col_d;
    row_q      <= row_d;
    val_q      <= val_d;
    left_q     <= left_d;
    mid_q      <= mid_d;
    save_q     <= save_d;
    res_cell_q <= res_cell_d;
    res_stat_q <= res_stat_d;
    cell_out_q <= cell_out_d;
    status_q   <= status_d;
    rd_vld_q   <= vld_q[ram_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign cell_out_o  = cell_out_q;
  assign status_o    = status_q;

endmodule

// ----- rtl/lgt_checker.sv -----
// Port-level checks for the life generation torus, bound to the top level.
// Depends on lgt_pkg and life_generation_torus_assert.svh.
`timescale 1ns / 1ps
`include "life_generation_torus_assert.svh"

module lgt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] req_type_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       cell_out_o,
  input logic       status_o
);

  logic [1:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Items accepted but not yet delivered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `LGT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(cell_out_o) && $stable(status_o),
                   "stalled result item changed")
  `LGT_ASSERT_IMPL(a_no_invented, clk_i, rst_ni, out_valid_o, pend_q != 2'd0,
                   "result item without an accepted request")
  `LGT_ASSERT_IMPL(a_one_in_work, clk_i, rst_ni, pend_q == 2'd2, in_stall_o,
                   "request accepted with two items outstanding")
  `LGT_ASSERT_IMPL(a_flag_clean, clk_i, rst_ni, out_valid_o && status_o, !cell_out_o,
                   "ignored request returned a live cell")
  `LGT_ASSERT_NEXT(a_step_busy, clk_i, rst_ni,
                   in_acc && (req_type_i == lgt_pkg::REQ_STEP), in_stall_o,
                   "generation step did not hold off the next item")

endmodule

bind life_generation_torus lgt_checker u_lgt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .req_type_i (req_type_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .cell_out_o (cell_out_o),
  .status_o   (status_o)
);
